[hdl/vsau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsau_pkg
// Shared types and codes of the video scroll address unit: event kinds,
// register numbers, the input and result words and the scroll state.
// ----------------------------------------------------------------------------
package vsau_pkg;

  localparam int AddrW = 15;
  localparam int BusW  = 14;

  // Event kinds
  localparam logic [2:0] KIND_REG_WR  = 3'd0;
  localparam logic [2:0] KIND_REG_RD  = 3'd1;
  localparam logic [2:0] KIND_CX_STEP = 3'd2;
  localparam logic [2:0] KIND_Y_STEP  = 3'd3;
  localparam logic [2:0] KIND_COPY_X  = 3'd4;
  localparam logic [2:0] KIND_COPY_Y  = 3'd5;

  // Register numbers within the window
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  // Last visible line and pre-render line
  localparam logic [8:0] LAST_VIS_LINE = 9'd239;
  localparam logic [8:0] PRE_LINE      = 9'd261;

  // Coarse y wrap points
  localparam logic [4:0] CY_LAST_ROW = 5'd29;
  localparam logic [4:0] CY_MAX      = 5'd31;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] reg_req;
    logic [7:0] data;
    logic [8:0] scanline;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] vram_addr;
    logic [AddrW-1:0] temp_addr_out;
    logic [BusW-1:0]  bus_addr;
    logic [2:0]       fine_x;
    logic             write_toggle;
  } out_item_t;

  typedef struct packed {
    logic [AddrW-1:0] cur;
    logic [AddrW-1:0] tmp;
    logic [2:0]       fine;
    logic             tog;
    logic             inc32;
    logic             ren;
  } scroll_state_t;

endpackage

[hdl/vsau_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsau_step
// Next-state logic: applies one event to the scroll state and forms the
// result word.
// ----------------------------------------------------------------------------
module vsau_step (
  input  vsau_pkg::in_item_t      item,
  input  vsau_pkg::scroll_state_t st,
  output vsau_pkg::scroll_state_t st_nxt,
  output vsau_pkg::out_item_t     res
);
  import vsau_pkg::*;

  function automatic logic [AddrW-1:0] coarse_x_step(input logic [AddrW-1:0] a);
    logic [AddrW-1:0] r;
    begin
      if (a[4:0] == CY_MAX) begin
        r = {a[14:11], ~a[10], a[9:5], 5'd0};
      end else begin
        r = {a[14:5], a[4:0] + 5'd1};
      end
      return r;
    end
  endfunction

  function automatic logic [AddrW-1:0] y_step(input logic [AddrW-1:0] a);
    logic [AddrW-1:0] r;
    begin
      if (a[14:12] != 3'd7) begin
        r = {a[14:12] + 3'd1, a[11:0]};
      end else if (a[9:5] == CY_LAST_ROW) begin
        r = {3'd0, ~a[11], a[10], 5'd0, a[4:0]};
      end else if (a[9:5] == CY_MAX) begin
        r = {3'd0, a[11:10], 5'd0, a[4:0]};
      end else begin
        r = {3'd0, a[11:10], a[9:5] + 5'd1, a[4:0]};
      end
      return r;
    end
  endfunction

  logic             render_line;
  logic [AddrW-1:0] inc_addr;
  logic [AddrW-1:0] tmp_lo;

  assign render_line = (item.scanline <= LAST_VIS_LINE) || (item.scanline == PRE_LINE);
  assign tmp_lo      = {st.tmp[14:8], item.data};

  always_comb begin
    if (st.ren && render_line) begin
      inc_addr = y_step(coarse_x_step(st.cur));
    end else if (st.inc32) begin
      inc_addr = st.cur + AddrW'(32);
    end else begin
      inc_addr = st.cur + AddrW'(1);
    end
  end

  always_comb begin
    st_nxt = st;
    case (item.kind)
      KIND_REG_WR: begin
        case (item.reg_req)
          REG_CTRL: begin
            st_nxt.tmp[11:10] = item.data[1:0];
            st_nxt.inc32      = item.data[2];
          end
          REG_MASK: st_nxt.ren = item.data[3] | item.data[4];
          REG_SCROLL: begin
            if (!st.tog) begin
              st_nxt.fine     = item.data[2:0];
              st_nxt.tmp[4:0] = item.data[7:3];
            end else begin
              st_nxt.tmp[14:12] = item.data[2:0];
              st_nxt.tmp[9:5]   = item.data[7:3];
            end
            st_nxt.tog = ~st.tog;
          end
          REG_ADDR: begin
            if (!st.tog) begin
              st_nxt.tmp = {1'b0, item.data[5:0], st.tmp[7:0]};
            end else begin
              st_nxt.tmp = tmp_lo;
              st_nxt.cur = tmp_lo;
            end
            st_nxt.tog = ~st.tog;
          end
          REG_DATA: st_nxt.cur = inc_addr;
          default: ;
        endcase
      end
      KIND_REG_RD: begin
        case (item.reg_req)
          REG_STATUS: st_nxt.tog = 1'b0;
          REG_DATA:   st_nxt.cur = inc_addr;
          default: ;
        endcase
      end
      KIND_CX_STEP: st_nxt.cur = coarse_x_step(st.cur);
      KIND_Y_STEP:  st_nxt.cur = y_step(st.cur);
      // horizontal bits: nametable x and coarse x
      KIND_COPY_X: st_nxt.cur = {st.cur[14:11], st.tmp[10], st.cur[9:5], st.tmp[4:0]};
      // vertical bits: fine y, nametable y and coarse y
      KIND_COPY_Y: st_nxt.cur = {st.tmp[14:11], st.cur[10], st.tmp[9:5], st.cur[4:0]};
      default: ;
    endcase
  end

  always_comb begin
    res.vram_addr     = st_nxt.cur;
    res.temp_addr_out = st_nxt.tmp;
    res.bus_addr      = st.cur[BusW-1:0];
    res.fine_x        = st_nxt.fine;
    res.write_toggle  = st_nxt.tog;
  end

endmodule

[hdl/video_scroll_address_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_scroll_address_unit
// Current/temporary address and scroll registers of a tile-based picture
// processor, driven by bus register accesses and render ticks.
// ----------------------------------------------------------------------------
// Path: input register, then result register. The scroll state update is
//   one combinational pass from the input register to the state and result
//   regs. Throughput: one word per cycle unless the result side stalls.
// Reset: synchronous, active low; clears both stage valids and all scroll
//   state (addresses, fine x, toggle, increment size, render enable).
module video_scroll_address_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vsau_pkg::in_item_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output vsau_pkg::out_item_t out_word
);
  import vsau_pkg::*;

  logic          in_valid_r;
  in_item_t      in_word_r;
  logic          out_valid_r;
  out_item_t     out_word_r;
  scroll_state_t st_r;
  scroll_state_t st_nxt;
  out_item_t     res;
  logic          advance;

  // move the held word on when the result register is free or being taken
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  vsau_step u_step (
    .item   (in_word_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[test/tb_video_scroll_address_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_video_scroll_address_unit
// Self-checking bench for the scroll address unit. A behavioural copy of the
// address and scroll state predicts every result word. The bench drives a
// short directed sequence and then random bus accesses and render ticks in
// bursts. The result side stalls in changing patterns. Each result word is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_video_scroll_address_unit;
  import vsau_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;
  localparam logic [2:0] REG_SPARE_3  = 3'd3;
  localparam logic [2:0] REG_SPARE_4  = 3'd4;

  localparam int RANDOM_WORDS = 1800;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  class scroll_tracker;
    scroll_state_t st;
    out_item_t     predicted[$];
    int            errors;

    function new();
      st = '0;
      errors = 0;
    endfunction

    function void step_coarse_x();
      if (&st.cur[4:0]) begin
        st.cur[4:0] = '0;
        st.cur[10]  = ~st.cur[10];
      end else begin
        st.cur[4:0] = st.cur[4:0] + 5'd1;
      end
    endfunction

    function void step_fine_y();
      if (!(&st.cur[14:12])) begin
        st.cur[14:12] = st.cur[14:12] + 3'd1;
      end else begin
        st.cur[14:12] = '0;
        case (st.cur[9:5])
          CY_LAST_ROW: begin
            st.cur[9:5] = '0;
            st.cur[11]  = ~st.cur[11];
          end
          CY_MAX: st.cur[9:5] = '0;
          default: st.cur[9:5] = st.cur[9:5] + 5'd1;
        endcase
      end
    endfunction

    // Data port access: render stepping on active lines, plain add otherwise
    function void bump_addr(logic [8:0] line);
      logic on_line;
      on_line = (line <= LAST_VIS_LINE) || (line == PRE_LINE);
      if (st.ren && on_line) begin
        step_coarse_x();
        step_fine_y();
      end else begin
        st.cur = st.cur + (st.inc32 ? 15'd32 : 15'd1);
      end
    endfunction

    function void write_reg(logic [2:0] rg, logic [7:0] d, logic [8:0] line);
      case (rg)
        REG_CTRL: begin
          st.tmp[11:10] = d[1:0];
          st.inc32      = d[2];
        end
        REG_MASK: st.ren = d[3] | d[4];
        REG_SCROLL: begin
          if (!st.tog) begin
            st.fine     = d[2:0];
            st.tmp[4:0] = d[7:3];
          end else begin
            st.tmp[14:12] = d[2:0];
            st.tmp[9:5]   = d[7:3];
          end
          st.tog = ~st.tog;
        end
        REG_ADDR: begin
          if (!st.tog) begin
            st.tmp[13:8] = d[5:0];
            st.tmp[14]   = 1'b0;
          end else begin
            st.tmp[7:0] = d;
            st.cur      = st.tmp;
          end
          st.tog = ~st.tog;
        end
        REG_DATA: bump_addr(line);
        default: ;
      endcase
    endfunction

    function void note_word(in_item_t w);
      out_item_t r;
      r.bus_addr = st.cur[BusW-1:0];
      case (w.kind)
        KIND_REG_WR: write_reg(w.reg_req, w.data, w.scanline);
        KIND_REG_RD: begin
          if (w.reg_req == REG_STATUS) st.tog = 1'b0;
          else if (w.reg_req == REG_DATA) bump_addr(w.scanline);
        end
        KIND_CX_STEP: step_coarse_x();
        KIND_Y_STEP:  step_fine_y();
        KIND_COPY_X: begin
          st.cur[10]  = st.tmp[10];
          st.cur[4:0] = st.tmp[4:0];
        end
        KIND_COPY_Y: begin
          st.cur[14:11] = st.tmp[14:11];
          st.cur[9:5]   = st.tmp[9:5];
        end
        default: ;
      endcase
      r.vram_addr     = st.cur;
      r.temp_addr_out = st.tmp;
      r.fine_x        = st.fine;
      r.write_toggle  = st.tog;
      predicted.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (predicted.size() == 0) begin
        $display("%0t: result word with nothing outstanding, expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = predicted.pop_front();
      compare_field("vram_addr", int'(want.vram_addr), int'(got.vram_addr));
      compare_field("temp_addr_out", int'(want.temp_addr_out), int'(got.temp_addr_out));
      compare_field("bus_addr", int'(want.bus_addr), int'(got.bus_addr));
      compare_field("fine_x", int'(want.fine_x), int'(got.fine_x));
      compare_field("write_toggle", int'(want.write_toggle), int'(got.write_toggle));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_word;

  stall_mode_e stall_mode = STALL_NONE;
  int          stall_phase = 0;
  int          idle_cycles = 0;

  scroll_tracker tracker;
  in_item_t      word_plan[$];

  video_scroll_address_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  // Result side: switch to a randomly chosen stall pattern whenever the phase count runs out
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  <= stall_mode_e'($urandom_range(0, 3));
      stall_phase <= $urandom_range(50, 300);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_phase[2:0] < 3'd3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.note_word(in_word);
    if (rst_n && out_valid && !out_stall) tracker.check_word(out_word);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_word(logic [2:0] kind, logic [2:0] rg, logic [7:0] d,
                                    logic [8:0] line);
    in_item_t w;
    w.kind     = kind;
    w.reg_req  = rg;
    w.data     = d;
    w.scanline = line;
    word_plan.push_back(w);
  endfunction

  function automatic logic [8:0] pick_line();
    case ($urandom_range(0, 4))
      0, 1:    return 9'($urandom_range(0, 239));
      2:       return PRE_LINE;
      3:       return 9'($urandom_range(240, 260));
      default: return 9'($urandom_range(262, 511));
    endcase
  endfunction

  function automatic void plan_directed();
    push_word(KIND_REG_WR, REG_CTRL, 8'hFF, 9'd0);      // nametable 3, step 32
    push_word(KIND_REG_WR, REG_SCROLL, 8'hFF, 9'd0);
    push_word(KIND_REG_WR, REG_SCROLL, 8'hFF, 9'd0);    // temp now all ones
    push_word(KIND_COPY_X, REG_SPARE_3, 8'h00, 9'd100);
    push_word(KIND_COPY_Y, REG_SPARE_4, 8'hFF, 9'd511);
    push_word(KIND_REG_WR, REG_DATA, 8'h00, 9'd511);    // add 32 wraps at 15 bits
    push_word(KIND_REG_WR, REG_CTRL, 8'h00, 9'd0);
    push_word(KIND_REG_RD, REG_DATA, 8'h00, 9'd300);
    push_word(KIND_REG_WR, REG_ADDR, 8'hFF, 9'd0);
    push_word(KIND_REG_RD, REG_STATUS, 8'h00, 9'd0);    // clear toggle mid-pair
    push_word(KIND_REG_WR, REG_ADDR, 8'h3F, 9'd0);
    push_word(KIND_REG_WR, REG_ADDR, 8'hFF, 9'd0);
    push_word(KIND_REG_WR, REG_MASK, 8'h18, 9'd0);
    push_word(KIND_REG_RD, REG_DATA, 8'h00, PRE_LINE);
    push_word(KIND_REG_WR, REG_DATA, 8'h00, LAST_VIS_LINE);
    push_word(KIND_REG_WR, REG_DATA, 8'h00, 9'd240);
    // Coarse y on the last row: y step flips the vertical nametable
    push_word(KIND_REG_WR, REG_SCROLL, 8'h00, 9'd0);
    push_word(KIND_REG_WR, REG_SCROLL, 8'hEF, 9'd0);
    push_word(KIND_COPY_Y, REG_CTRL, 8'h00, 9'd0);
    push_word(KIND_Y_STEP, REG_CTRL, 8'h00, 9'd0);
    push_word(KIND_CX_STEP, REG_CTRL, 8'h00, 9'd0);
    push_word(KIND_REG_WR, REG_MASK, 8'h08, 9'd0);
    push_word(KIND_SPARE_6, REG_SCROLL, 8'hAA, 9'd10);
    push_word(KIND_SPARE_7, REG_ADDR, 8'h55, 9'd20);
    push_word(KIND_REG_WR, REG_SPARE_3, 8'hE7, 9'd0);
    push_word(KIND_REG_RD, REG_CTRL, 8'h00, 9'd0);
  endfunction

  function automatic void plan_random();
    int target;
    int pick;
    logic [31:0] rnd;
    logic [$bits(in_item_t)-1:0] raw;
    target = word_plan.size() + RANDOM_WORDS;
    while (word_plan.size() < target) begin
      pick = $urandom_range(0, 19);
      if (pick <= 6) begin
        push_word(3'($urandom_range(KIND_CX_STEP, KIND_COPY_Y)), 3'($urandom()),
                  8'($urandom()), pick_line());
      end else if (pick <= 8) begin
        if ($urandom_range(0, 1)) push_word(KIND_REG_RD, REG_STATUS, 8'($urandom()), pick_line());
        push_word(KIND_REG_WR, REG_SCROLL, 8'($urandom()), pick_line());
        push_word(KIND_REG_WR, REG_SCROLL, 8'($urandom()), pick_line());
      end else if (pick <= 10) begin
        push_word(KIND_REG_WR, REG_ADDR, 8'($urandom()), pick_line());
        push_word(KIND_REG_WR, REG_ADDR, 8'($urandom()), pick_line());
      end else if (pick == 11) begin
        push_word(KIND_REG_RD, REG_STATUS, 8'($urandom()), pick_line());
      end else if (pick <= 13) begin
        push_word($urandom_range(0, 1) ? KIND_REG_WR : KIND_REG_RD, REG_DATA,
                  8'($urandom()), pick_line());
      end else if (pick == 14) begin
        push_word(KIND_REG_WR, REG_CTRL, 8'($urandom()), pick_line());
      end else if (pick == 15) begin
        push_word(KIND_REG_WR, REG_MASK, 8'($urandom()), pick_line());
      end else if (pick == 16) begin
        // One tile row fetch: coarse steps, then y step and horizontal reload
        repeat ($urandom_range(4, 34)) push_word(KIND_CX_STEP, REG_CTRL, 8'h00, pick_line());
        push_word(KIND_Y_STEP, REG_CTRL, 8'h00, pick_line());
        push_word(KIND_COPY_X, REG_CTRL, 8'h00, pick_line());
      end else begin
        rnd = $urandom();
        raw = rnd[$bits(in_item_t)-1:0];
        word_plan.push_back(raw);
      end
    end
  endfunction

  task automatic send_plan();
    int burst;
    int gap;
    burst = 0;
    foreach (word_plan[i]) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 48);
      end
      in_valid <= 1'b1;
      in_word  <= word_plan[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    tracker = new();
    plan_directed();
    plan_random();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_plan();
    while (tracker.predicted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("video_scroll_address_unit test passed");
    end else begin
      $display("video_scroll_address_unit test failed");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("video_scroll_address_unit test failed");
    $finish;
  end

endmodule

[sim.f]
hdl/vsau_pkg.sv
hdl/vsau_step.sv
hdl/video_scroll_address_unit.sv
test/tb_video_scroll_address_unit.sv
